### design/upso_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the unordered pair set operation core.
// No dependencies.
package upso_pkg;

  localparam int DEFAULT_CAPACITY = 32;
  localparam int MAX_RESULTS      = 32;
  localparam int RES_W            = $clog2(MAX_RESULTS + 1);

  localparam logic OP_INTERSECT = 1'b0;
  localparam logic OP_DIFF      = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_OPERATION = 1'b0;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } pair_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

### design/unordered_pair_set_operation_core.sv
`timescale 1ns / 1ps
// Top level: request handling, sequencer, config register, result output.
// Depends on upso_pkg, upso_mem, upso_cmp.
//
// Usage: a request is taken when start is high and busy is low. A request
// with in_has_pair stores its pair (smaller value first) in set A or B; the
// store is kept sorted by insertion, one shared comparator stepping down the
// set and moving each larger entry up one place. With in_end_of_job the
// sets are merged once any insertion is done. Results appear as one-cycle
// out_valid strobes; the final one carries out_last. An empty result gives
// a single item with out_is_empty set.
// The receiver cannot stall; results are never held back.
// The operation register (byte address 0, bit 0) picks intersection (0) or
// A minus B (1); write it only while idle. Reset clears counts, the overflow
// flag and the operation register; store contents are never read before use.
module unordered_pair_set_operation_core #(
  parameter int CAPACITY = upso_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        in_which_set,
  input  logic [63:0] in_first_value,
  input  logic [63:0] in_second_value,
  input  logic        in_has_pair,
  input  logic        in_end_of_job,
  output logic        out_valid,
  output logic [63:0] out_low_value,
  output logic [63:0] out_high_value,
  output logic        out_is_empty,
  output logic        out_overflow,
  output logic        out_last
);
  import upso_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0]    CAP_C   = CW'(CAPACITY);
  localparam logic [RES_W-1:0] MAXR_C  = RES_W'(MAX_RESULTS);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_MRG_RD  = 6'b001000,
    S_MRG_CMP = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic              op_r;
  logic [CW-1:0]     cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [RES_W-1:0]  n_r, n_nxt;
  logic              ovf_r, ovf_nxt;
  logic              which_r, which_nxt, eoj_r, eoj_nxt;
  pair_t             key_r, key_nxt;
  logic              pend_v_r, pend_v_nxt;
  pair_t             pend_r, pend_nxt;
  logic              ov_r, ov_nxt, oe_r, oe_nxt, oo_r, oo_nxt, ol_r, ol_nxt;
  pair_t             op_pair_r, op_pair_nxt;

  logic              accept, cfg_wr;
  logic              we_a, we_b;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  pair_t             wdata, rdata_a, rdata_b, cmp_x, cmp_y;
  cmp_res_t          cres;

  assign pready = 1'b1;
  assign prdata = {31'd0, op_r};
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OPERATION);
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_INTERSECT;
    end else if (cfg_wr) begin
      op_r <= pwdata[0];
    end
  end

  upso_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr_a), .rdata(rdata_a)
  );
  upso_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr_b), .rdata(rdata_b)
  );

  upso_cmp u_cmp (.x(cmp_x), .y(cmp_y), .res(cres));

  assign raddr_a = (state_r == S_INS_RD) ? (pos_r - 1'b1) : i_r[AW-1:0];
  assign raddr_b = (state_r == S_INS_RD) ? (pos_r - 1'b1) : j_r[AW-1:0];
  assign cmp_x   = (state_r == S_INS_CMP && which_r) ? rdata_b : rdata_a;
  assign cmp_y   = (state_r == S_INS_CMP) ? key_r : rdata_b;

  always_comb begin
    logic emit;
    logic done_ins;
    emit        = 1'b0;
    done_ins    = 1'b0;
    state_nxt   = state_r;
    cnt_a_nxt   = cnt_a_r;
    cnt_b_nxt   = cnt_b_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    pos_nxt     = pos_r;
    n_nxt       = n_r;
    ovf_nxt     = ovf_r;
    which_nxt   = which_r;
    eoj_nxt     = eoj_r;
    key_nxt     = key_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    ov_nxt      = 1'b0;
    oe_nxt      = oe_r;
    oo_nxt      = oo_r;
    ol_nxt      = ol_r;
    op_pair_nxt = op_pair_r;
    we_a        = 1'b0;
    we_b        = 1'b0;
    waddr       = pos_r;
    wdata       = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          which_nxt  = in_which_set;
          eoj_nxt    = in_end_of_job;
          key_nxt.lo = (in_second_value < in_first_value) ? in_second_value : in_first_value;
          key_nxt.hi = (in_second_value < in_first_value) ? in_first_value : in_second_value;
          i_nxt      = '0;
          j_nxt      = '0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          if (in_has_pair && (in_which_set ? (cnt_b_r < CAP_C) : (cnt_a_r < CAP_C))) begin
            pos_nxt   = in_which_set ? cnt_b_r[AW-1:0] : cnt_a_r[AW-1:0];
            state_nxt = S_INS_RD;
          end else begin
            if (in_has_pair) ovf_nxt = 1'b1;
            state_nxt = in_end_of_job ? S_MRG_RD : S_IDLE;
          end
        end
      end
      S_INS_RD: begin
        if (pos_r == '0) begin
          done_ins = 1'b1;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (cres.gt) begin
          // shift the larger entry up one place
          wdata   = cmp_x;
          we_a    = !which_r;
          we_b    = which_r;
          pos_nxt = pos_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          done_ins = 1'b1;
        end
      end
      S_MRG_RD: begin
        state_nxt = ((i_r >= cnt_a_r) || (n_r == MAXR_C)) ? S_FINISH : S_MRG_CMP;
      end
      S_MRG_CMP: begin
        state_nxt = S_MRG_RD;
        if (j_r >= cnt_b_r) begin
          if (op_r == OP_INTERSECT) begin
            state_nxt = S_FINISH;
          end else begin
            emit  = 1'b1;
            i_nxt = i_r + 1'b1;
          end
        end else if (cres.lt) begin
          emit  = (op_r == OP_DIFF);
          i_nxt = i_r + 1'b1;
        end else if (cres.gt) begin
          j_nxt = j_r + 1'b1;
        end else begin
          emit  = (op_r == OP_INTERSECT);
          i_nxt = i_r + 1'b1;
          j_nxt = j_r + 1'b1;
        end
      end
      S_FINISH: begin
        ov_nxt      = 1'b1;
        oo_nxt      = ovf_r;
        ol_nxt      = 1'b1;
        oe_nxt      = !pend_v_r;
        op_pair_nxt = pend_v_r ? pend_r : '0;
        cnt_a_nxt   = '0;
        cnt_b_nxt   = '0;
        ovf_nxt     = 1'b0;
        pend_v_nxt  = 1'b0;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (done_ins) begin
      wdata = key_r;
      we_a  = !which_r;
      we_b  = which_r;
      if (which_r) cnt_b_nxt = cnt_b_r + 1'b1;
      else         cnt_a_nxt = cnt_a_r + 1'b1;
      state_nxt = eoj_r ? S_MRG_RD : S_IDLE;
    end

    // results go out one step late so the final one can carry last
    if (emit) begin
      if (pend_v_r) begin
        ov_nxt      = 1'b1;
        oo_nxt      = ovf_r;
        ol_nxt      = 1'b0;
        oe_nxt      = 1'b0;
        op_pair_nxt = pend_r;
      end
      pend_nxt   = rdata_a;
      pend_v_nxt = 1'b1;
      n_nxt      = n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    pos_r     <= pos_nxt;
    n_r       <= n_nxt;
    which_r   <= which_nxt;
    eoj_r     <= eoj_nxt;
    key_r     <= key_nxt;
    pend_r    <= pend_nxt;
    oe_r      <= oe_nxt;
    oo_r      <= oo_nxt;
    ol_r      <= ol_nxt;
    op_pair_r <= op_pair_nxt;
  end

  assign out_valid      = ov_r;
  assign out_low_value  = op_pair_r.lo;
  assign out_high_value = op_pair_r.hi;
  assign out_is_empty   = oe_r;
  assign out_overflow   = oo_r;
  assign out_last       = ol_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_last)
    else $error("empty result without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_low_value == 64'd0) && (out_high_value == 64'd0))
    else $error("empty result carries a pair");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CAP_C) && (cnt_b_r <= CAP_C))
    else $error("set count beyond capacity");

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result while idle");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (cnt_a_r == '0) && (cnt_b_r == '0) && !busy)
    else $error("job state not cleared at last result");

endmodule

### design/upso_mem.sv
`timescale 1ns / 1ps
// Pair store: one write port, one registered read port.
// Depends on upso_pkg for pair_t.
module upso_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  upso_pkg::pair_t  wdata,
  input  logic [AW-1:0]    raddr,
  output upso_pkg::pair_t  rdata
);
  import upso_pkg::*;

  pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/upso_cmp.sv
`timescale 1ns / 1ps
// Shared lexicographic pair comparator (low value first, then high value).
// Depends on upso_pkg.
module upso_cmp (
  input  upso_pkg::pair_t    x,
  input  upso_pkg::pair_t    y,
  output upso_pkg::cmp_res_t res
);
  import upso_pkg::*;

  always_comb begin
    res.lt = (x.lo < y.lo) || ((x.lo == y.lo) && (x.hi < y.hi));
    res.gt = (x.lo > y.lo) || ((x.lo == y.lo) && (x.hi > y.hi));
  end

endmodule
